FILE: rtl/vroq_pkg.sv
// shared types and constants for the vruntime ordered run queue
// used by vroq_cell and vruntime_ordered_run_queue_core; no dependencies
`timescale 1ns / 1ps

package vroq_pkg;

  localparam int KEY_W    = 64;
  localparam int ID_W     = 6;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;
  localparam int QCOUNT_W = 7;

  // operation codes
  localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
  localparam logic [OP_W-1:0] OP_PICK    = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd4;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
  } entry_t;

  // per-beat update command broadcast to every cell
  typedef struct packed {
    logic ins_en;
    logic del_en;
  } cell_ctrl_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } fsm_t;

endpackage

FILE: rtl/vroq_cell.sv
// one slot of the sorted run queue chain: holds a key and id, compares them
// against the incoming beat and shifts with its neighbors; uses vroq_pkg
`timescale 1ns / 1ps

module vroq_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  logic [vroq_pkg::KEY_W-1:0] cmp_key,
  input  logic [vroq_pkg::ID_W-1:0]  cmp_id,
  input  logic                      occupied,
  input  logic                      tail,
  input  vroq_pkg::cell_ctrl_t      ctrl,
  input  vroq_pkg::entry_t          new_entry,
  input  vroq_pkg::entry_t          left,
  input  vroq_pkg::entry_t          right,
  input  logic                      ins_seen_in,
  input  logic                      del_seen_in,
  output logic                      ins_seen_out,
  output logic                      del_seen_out,
  output vroq_pkg::entry_t          entry_out
);

  vroq_pkg::entry_t           entry_r;
  vroq_pkg::entry_t           entry_nxt;
  logic                       entry_we;
  logic                       before_r;
  logic                       match_r;
  logic [vroq_pkg::KEY_W-1:0] diff;

  // wrap-aware order: new key goes first when (new - held) is negative
  assign diff = cmp_key - entry_r.key;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      before_r <= 1'b0;
      match_r  <= 1'b0;
    end else if (load) begin
      before_r <= occupied & diff[vroq_pkg::KEY_W-1];
      match_r  <= occupied & (entry_r.id == cmp_id);
    end
  end

  assign ins_seen_out = ins_seen_in | before_r;
  assign del_seen_out = del_seen_in | match_r;

  always_comb begin
    entry_we  = 1'b0;
    entry_nxt = entry_r;
    if (ctrl.ins_en) begin
      if (ins_seen_in) begin
        entry_we  = 1'b1;
        entry_nxt = left;
      end else if (before_r || tail) begin
        entry_we  = 1'b1;
        entry_nxt = new_entry;
      end
    end else if (ctrl.del_en && del_seen_out) begin
      entry_we  = 1'b1;
      entry_nxt = right;
    end
  end

  always_ff @(posedge clk) begin
    if (entry_we) begin
      entry_r <= entry_nxt;
    end
  end

  assign entry_out = entry_r;

endmodule

FILE: rtl/vruntime_ordered_run_queue_core.sv
// top level of the vruntime ordered run queue: a chain of vroq_cell slots
// kept in key order, an item sequencer and a registered result stage; uses vroq_pkg
`timescale 1ns / 1ps

// usage
//   input beats carry one operation each: enqueue (id, key), dequeue (id) or
//   pick. the operation code rides on in_tuser, id and key on in_tdata.
//   every input beat yields exactly one result beat on the out_ channel with
//   a status, the picked task (pick only) and the queue occupancy after the op.
// timing
//   on accept, every cell compares its key and id with the beat and
//   registers the outcome. on commit, the cells shift or load in one
//   step along the chain and the result lands in the output register.
//   result shows on out_tvalid the cycle after commit. a new beat is taken
//   only once the last one has committed; the pair of steps is set by the
//   per-cell compare register feeding the neighbor-to-neighbor shift chain.
// reset
//   rst_n (synchronous, active low) empties the queue, clears the current
//   task record and drops out_tvalid; slot contents are left as they are.
// backpressure
//   while a result waits on out_tready the block still accepts one more
//   beat and evaluates it; its commit holds until the output register frees.
module vruntime_ordered_run_queue_core #(
  parameter int MAX_TASKS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [5:0] task_id, [69:6] vruntime_key, [71:70] zero
  input  logic [1:0]  in_tuser,   // [1:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [5:0] picked_task, [12:6] queued_count, [15:13] zero
  output logic [3:0]  out_tuser   // [2:0] status, [3] picked_valid
);

  localparam int CW = $clog2(MAX_TASKS + 1);

  // sequencer
  vroq_pkg::fsm_t state_r, state_nxt;
  logic in_fire;
  logic commit;

  // latched beat
  logic [vroq_pkg::OP_W-1:0] op_r;
  vroq_pkg::entry_t          item_r;

  // queue bookkeeping
  logic [CW-1:0]             count_r, count_nxt;
  logic [vroq_pkg::ID_W-1:0] current_task_r, current_task_nxt;
  logic                      current_valid_r, current_valid_nxt;

  // result register
  logic                          out_valid_r;
  logic [vroq_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [vroq_pkg::ID_W-1:0]     picked_r, picked_nxt;
  logic                          pvalid_r, pvalid_nxt;
  logic [CW-1:0]                 qcount_r;

  // chain wiring
  vroq_pkg::entry_t     cell_q [MAX_TASKS];
  logic [MAX_TASKS:0]   ins_chain;
  logic [MAX_TASKS:0]   del_chain;
  vroq_pkg::cell_ctrl_t ctrl;
  logic                 any_match;
  logic                 full;
  logic                 empty;

  assign in_tready = (state_r == vroq_pkg::S_IDLE);
  assign in_fire   = in_tvalid & in_tready;
  assign commit    = (state_r == vroq_pkg::S_EXEC) & (~out_valid_r | out_tready);

  assign ins_chain[0] = 1'b0;
  assign del_chain[0] = 1'b0;
  assign any_match    = del_chain[MAX_TASKS];
  assign full         = (count_r == CW'(MAX_TASKS));
  assign empty        = (count_r == '0);

  // row of slots, head at index 0
  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    vroq_pkg::entry_t left_e, right_e;
    logic             occ, tl;

    assign occ = (CW'(i) < count_r);
    assign tl  = (CW'(i) == count_r);

    if (i == 0) begin : g_head
      assign left_e = item_r;
    end else begin : g_mid_l
      assign left_e = cell_q[i-1];
    end

    if (i == MAX_TASKS - 1) begin : g_tail
      assign right_e = item_r;
    end else begin : g_mid_r
      assign right_e = cell_q[i+1];
    end

    vroq_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .load         (in_fire),
      .cmp_key      (in_tdata[69:6]),
      .cmp_id       (in_tdata[5:0]),
      .occupied     (occ),
      .tail         (tl),
      .ctrl         (ctrl),
      .new_entry    (item_r),
      .left         (left_e),
      .right        (right_e),
      .ins_seen_in  (ins_chain[i]),
      .del_seen_in  (del_chain[i]),
      .ins_seen_out (ins_chain[i+1]),
      .del_seen_out (del_chain[i+1]),
      .entry_out    (cell_q[i])
    );
  end

  // next state, update command and result
  always_comb begin
    state_nxt         = state_r;
    ctrl              = '0;
    count_nxt         = count_r;
    current_task_nxt  = current_task_r;
    current_valid_nxt = current_valid_r;
    status_nxt        = vroq_pkg::STAT_OK;
    picked_nxt        = '0;
    pvalid_nxt        = 1'b0;

    case (state_r)
      vroq_pkg::S_IDLE: begin
        if (in_fire) begin
          state_nxt = vroq_pkg::S_EXEC;
        end
      end
      vroq_pkg::S_EXEC: begin
        if (commit) begin
          state_nxt = vroq_pkg::S_IDLE;
          case (op_r)
            vroq_pkg::OP_ENQUEUE: begin
              // duplicate check comes before fullness
              if (any_match) begin
                status_nxt = vroq_pkg::STAT_DUPLICATE;
              end else if (full) begin
                status_nxt = vroq_pkg::STAT_FULL;
              end else begin
                ctrl.ins_en = 1'b1;
                count_nxt   = count_r + CW'(1);
              end
            end
            vroq_pkg::OP_DEQUEUE: begin
              if (!any_match) begin
                status_nxt = vroq_pkg::STAT_NOT_FOUND;
              end else begin
                ctrl.del_en = 1'b1;
                count_nxt   = count_r - CW'(1);
              end
            end
            vroq_pkg::OP_PICK: begin
              if (empty) begin
                status_nxt = vroq_pkg::STAT_EMPTY;
              end else begin
                current_task_nxt  = cell_q[0].id;
                current_valid_nxt = 1'b1;
                picked_nxt        = cell_q[0].id;
                pvalid_nxt        = 1'b1;
              end
            end
            default: begin
              // unused code: no change, status ok
            end
          endcase
        end
      end
      default: begin
        state_nxt = vroq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= vroq_pkg::S_IDLE;
      count_r         <= '0;
      current_task_r  <= '0;
      current_valid_r <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      count_r         <= count_nxt;
      current_task_r  <= current_task_nxt;
      current_valid_r <= current_valid_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r       <= in_tuser;
      item_r.id  <= in_tdata[5:0];
      item_r.key <= in_tdata[69:6];
    end
    if (commit) begin
      status_r <= status_nxt;
      picked_r <= picked_nxt;
      pvalid_r <= pvalid_nxt;
      qcount_r <= count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, vroq_pkg::QCOUNT_W'(qcount_r), picked_r};
  assign out_tuser  = {pvalid_r, status_r};

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_TASKS))
    else $error("queue occupancy above capacity");

  a_pick_sets_current: assert property (@(posedge clk) disable iff (!rst_n)
    commit && (op_r == vroq_pkg::OP_PICK) && !empty
      |=> current_valid_r && (current_task_r == picked_r))
    else $error("pick did not record the current task");

  a_dequeue_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    commit && (op_r == vroq_pkg::OP_DEQUEUE) && any_match
      |=> count_r == $past(count_r) - CW'(1))
    else $error("dequeue did not shrink the queue");

  a_result_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r && (qcount_r == count_r))
    else $error("result occupancy disagrees with queue");

endmodule

FILE: bench/tb_top.sv
// self-checking bench for vruntime_ordered_run_queue_core: random and directed
// enqueue, dequeue and pick beats against a shadow run queue; uses vroq_pkg
`timescale 1ns / 1ps

module tb_top;
  import vroq_pkg::*;

  localparam int QDEPTH = 64;
  // the fourth operation code has no meaning and must leave the queue alone
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // key styles for the random phases
  localparam int KEYS_WIDE    = 0;  // full 64-bit spread
  localparam int KEYS_CLUSTER = 1;  // narrow window above a base, many ties
  localparam int KEYS_WRAP    = 2;  // around zero and the signed midpoint

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     picked;
    logic                valid;
    logic [QCOUNT_W-1:0] count;
  } run_result_t;

  // shadow copy of the run queue plus the expected result beats in order
  class run_queue_shadow;
    logic [KEY_W-1:0] keys [QDEPTH];
    logic [ID_W-1:0]  ids  [QDEPTH];
    int               count = 0;
    logic [ID_W-1:0]  cur_task = '0;
    logic             cur_valid = 1'b0;
    run_result_t      expected_beats [$];
    int               errors = 0;

    // wrap-aware order: a before b when a - b is negative as signed 64 bits
    function bit key_before(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
      logic [KEY_W-1:0] d;
      d = a - b;
      return d[KEY_W-1];
    endfunction

    function int find_slot(logic [ID_W-1:0] id);
      for (int i = 0; i < count; i++)
        if (ids[i] == id) return i;
      return count;
    endfunction

    function bit is_queued(logic [ID_W-1:0] id);
      return find_slot(id) < count;
    endfunction

    // apply one accepted input beat and queue the result it must produce
    function void accept_op(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                            logic [KEY_W-1:0] key);
      run_result_t r;
      int pos;
      r.status = STAT_OK;
      r.picked = '0;
      r.valid  = 1'b0;
      case (op)
        OP_ENQUEUE: begin
          if (is_queued(id)) begin
            r.status = STAT_DUPLICATE;
          end else if (count >= QDEPTH) begin
            r.status = STAT_FULL;
          end else begin
            pos = count;
            for (int i = 0; i < count; i++)
              if (key_before(key, keys[i])) begin
                pos = i;
                break;
              end
            for (int i = count; i > pos; i--) begin
              keys[i] = keys[i-1];
              ids[i]  = ids[i-1];
            end
            keys[pos] = key;
            ids[pos]  = id;
            count++;
          end
        end
        OP_DEQUEUE: begin
          pos = find_slot(id);
          if (pos >= count) begin
            r.status = STAT_NOT_FOUND;
          end else begin
            for (int i = pos; i + 1 < count; i++) begin
              keys[i] = keys[i+1];
              ids[i]  = ids[i+1];
            end
            count--;
          end
        end
        OP_PICK: begin
          if (count == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            cur_task  = ids[0];
            cur_valid = 1'b1;
            r.picked  = cur_task;
            r.valid   = 1'b1;
          end
        end
        default: ;
      endcase
      r.count = count[QCOUNT_W-1:0];
      expected_beats.push_back(r);
    endfunction

    function void note_error(string field, int exp_v, int act_v);
      errors++;
      if (errors <= 10)
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, field,
                 exp_v, act_v);
    endfunction

    // compare one accepted result beat with the oldest expectation
    function void match_result(logic [15:0] tdata, logic [3:0] tuser);
      run_result_t e;
      if (expected_beats.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] result beat with nothing expected: tdata %h tuser %h",
                   $realtime, tdata, tuser);
        return;
      end
      e = expected_beats.pop_front();
      if (tuser[2:0] !== e.status) note_error("status", e.status, tuser[2:0]);
      if (tuser[3] !== e.valid) note_error("picked_valid", e.valid, tuser[3]);
      if (tdata[5:0] !== e.picked) note_error("picked_task", e.picked, tdata[5:0]);
      if (tdata[12:6] !== e.count) note_error("queued_count", e.count, tdata[12:6]);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;    // [5:0] task_id, [69:6] vruntime_key, [71:70] zero
  logic [1:0]  in_tuser = '0;    // [1:0] operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;        // [5:0] picked_task, [12:6] queued_count, [15:13] zero
  logic [3:0]  out_tuser;        // [2:0] status, [3] picked_valid

  run_queue_shadow shadow = new;

  // stimulus knobs shared by the driver and the ready generator
  bit               calm = 1'b0;     // no new gaps on either side while set
  int               key_style = KEYS_WIDE;
  logic [KEY_W-1:0] key_base = '0;
  int               sent = 0;
  int               stall_left = 0;

  vruntime_ordered_run_queue_core #(.MAX_TASKS(QDEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // result side backpressure: mostly ready, short stalls, now and then a long one
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (calm) begin
      out_tready <= 1'b1;
    end else if ($urandom_range(0, 99) < 70) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b0;
      // this edge counts as the first stall cycle
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) - 1
                                              : $urandom_range(1, 3) - 1;
    end
  end

  // result monitor: sampled at the edge, before this edge's updates land
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      shadow.match_result(out_tdata, out_tuser);
  end

  // idle cycles before the next input beat
  function int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function logic [KEY_W-1:0] make_key();
    logic [KEY_W-1:0] k;
    case (key_style)
      KEYS_CLUSTER: k = key_base + KEY_W'($urandom_range(0, 15));
      KEYS_WRAP: begin
        case ($urandom_range(0, 3))
          0: k = '0;
          1: k = '1;
          2: k = {1'b1, {(KEY_W-1){1'b0}}};
          default: k = {1'b0, {(KEY_W-1){1'b1}}};
        endcase
        k = k + KEY_W'($urandom_range(0, 6)) - KEY_W'(3);
      end
      default: k = {$urandom, $urandom};
    endcase
    return k;
  endfunction

  function logic [ID_W-1:0] free_id();
    logic [ID_W-1:0] c;
    do c = ID_W'($urandom_range(0, 63)); while (shadow.is_queued(c));
    return c;
  endfunction

  function logic [ID_W-1:0] queued_id();
    return shadow.ids[$urandom_range(0, shadow.count - 1)];
  endfunction

  // present one beat and hold it until the block takes it
  task automatic send_op(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                         input logic [KEY_W-1:0] key);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, key, id};
    do @(posedge clk); while (!in_tready);
    shadow.accept_op(op, id, key);
    sent++;
  endtask

  task automatic random_noise_op();
    send_op(($urandom_range(0, 1) == 0) ? OP_PICK : OP_UNUSED,
            ID_W'($urandom_range(0, 63)), {$urandom, $urandom});
  endtask

  // random mix of all operations, ids mostly chosen to succeed
  task automatic mixed_phase(input int len);
    int r;
    for (int n = 0; n < len; n++) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        if (shadow.count < QDEPTH && $urandom_range(0, 9) < 8)
          send_op(OP_ENQUEUE, free_id(), make_key());
        else
          send_op(OP_ENQUEUE, ID_W'($urandom_range(0, 63)), make_key());
      end else if (r < 70) begin
        if (shadow.count > 0 && $urandom_range(0, 9) < 8)
          send_op(OP_DEQUEUE, queued_id(), {$urandom, $urandom});
        else
          send_op(OP_DEQUEUE, ID_W'($urandom_range(0, 63)), {$urandom, $urandom});
      end else if (r < 95) begin
        send_op(OP_PICK, ID_W'($urandom_range(0, 63)), {$urandom, $urandom});
      end else begin
        send_op(OP_UNUSED, ID_W'($urandom_range(0, 63)), {$urandom, $urandom});
      end
    end
  endtask

  // fill every slot, then try to add more (always duplicates at full depth)
  task automatic fill_phase();
    while (shadow.count < QDEPTH) begin
      if ($urandom_range(0, 7) == 0) random_noise_op();
      send_op(OP_ENQUEUE, free_id(), make_key());
    end
    repeat (3) send_op(OP_ENQUEUE, ID_W'($urandom_range(0, 63)), make_key());
    send_op(OP_PICK, '0, '0);
  endtask

  // empty the queue in random order with picks along the way
  task automatic drain_phase();
    while (shadow.count > 0) begin
      if ($urandom_range(0, 4) == 0)
        send_op(OP_PICK, ID_W'($urandom_range(0, 63)), {$urandom, $urandom});
      else
        send_op(OP_DEQUEUE, queued_id(), {$urandom, $urandom});
    end
    send_op(OP_PICK, ID_W'($urandom_range(0, 63)), {$urandom, $urandom});
    send_op(OP_DEQUEUE, ID_W'($urandom_range(0, 63)), {$urandom, $urandom});
  endtask

  initial begin
    int target;
    int r;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty queue errors and the unused code
    send_op(OP_PICK, '0, '0);
    send_op(OP_DEQUEUE, 6'd7, '0);
    send_op(OP_UNUSED, 6'd63, '1);
    // key extremes, wrap-around ordering, tie placed after its equal
    send_op(OP_ENQUEUE, 6'd0, '0);
    send_op(OP_ENQUEUE, 6'd63, '1);
    send_op(OP_ENQUEUE, 6'd42, {1'b1, 63'd0});
    send_op(OP_ENQUEUE, 6'd21, {1'b0, {63{1'b1}}});
    send_op(OP_ENQUEUE, 6'd5, '0);
    // duplicate id is rejected
    send_op(OP_ENQUEUE, 6'd0, 64'd5);
    send_op(OP_PICK, '1, '1);
    // remove the current task, the record of it stays
    send_op(OP_DEQUEUE, shadow.cur_task, '0);
    send_op(OP_PICK, '0, '0);
    send_op(OP_DEQUEUE, 6'd9, '1);
    send_op(OP_UNUSED, '0, '0);
    // drain from the tail, then the head, leaving it empty
    send_op(OP_DEQUEUE, shadow.ids[shadow.count - 1], '0);
    while (shadow.count > 0) send_op(OP_DEQUEUE, shadow.ids[0], '0);
    send_op(OP_PICK, '0, '0);

    // random phases
    target = sent + 600;
    while (sent < target) begin
      calm      = ($urandom_range(0, 3) == 0);
      key_style = $urandom_range(KEYS_WIDE, KEYS_WRAP);
      key_base  = {$urandom, $urandom};
      r = $urandom_range(0, 99);
      if (r < 50) mixed_phase($urandom_range(20, 40));
      else if (r < 75) fill_phase();
      else drain_phase();
    end
    in_tvalid <= 1'b0;
    calm = 1'b0;

    // let the last results drain, then keep watching for stray beats
    while (shadow.expected_beats.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (shadow.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", shadow.expected_beats.size());
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/vroq_pkg.sv
rtl/vroq_cell.sv
rtl/vruntime_ordered_run_queue_core.sv
bench/tb_top.sv
